### hw/rtl/ata_pkg.sv
// Package with shared types, codes and constants for the ATA PIO command sequencer.
`timescale 1ns / 1ps
`default_nettype none
package ata_pkg;

    localparam int ADDRESS_BITS = 28;
    localparam int WORDS_PER_SECTOR = 256;

    localparam logic [1:0] MODE_CMD = 2'd0;
    localparam logic [1:0] MODE_STATUS = 2'd1;
    localparam logic [1:0] MODE_DEV_WORD = 2'd2;
    localparam logic [1:0] MODE_HOST_WORD = 2'd3;

    localparam logic [1:0] OP_READ = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_IDENTIFY = 2'd2;

    localparam logic [1:0] KIND_REG_WRITE = 2'd0;
    localparam logic [1:0] KIND_REG_READ = 2'd1;
    localparam logic [1:0] KIND_HOST_WORD = 2'd2;
    localparam logic [1:0] KIND_DONE = 2'd3;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_IO = 2'd1;
    localparam logic [1:0] ERR_POLL_EXPIRED = 2'd2;

    localparam logic [2:0] REG_DATA = 3'd0;
    localparam logic [2:0] REG_COUNT = 3'd2;
    localparam logic [2:0] REG_LBA0 = 3'd3;
    localparam logic [2:0] REG_LBA1 = 3'd4;
    localparam logic [2:0] REG_LBA2 = 3'd5;
    localparam logic [2:0] REG_DRIVE = 3'd6;
    localparam logic [2:0] REG_CMD = 3'd7;

    localparam logic [7:0] DRIVE_BASE = 8'he0;
    localparam logic [7:0] CMD_IDENTIFY = 8'hec;
    localparam logic [7:0] CMD_READ = 8'h20;
    localparam logic [7:0] CMD_WRITE = 8'h30;
    localparam logic [15:0] POLL_LIMIT_RESET = 16'd10000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = 2;

    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] op;
        logic bus_index;
        logic drive_index;
        logic [47:0] block_address;
        logic [7:0] sector_count;
        logic [7:0] status_byte;
        logic [15:0] data_word;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic bus_out;
        logic [2:0] register_index;
        logic [15:0] value;
        logic [1:0] error_code;
        logic [27:0] capacity;
        logic last;
    } out_item_t;

    // Classified item passed from the front part to the back part.
    typedef struct packed {
        logic [1:0] mode;
        logic [1:0] op;
        logic bus_index;
        logic drive_index;
        logic addr_too_big;
        logic [27:0] address;
        logic [7:0] sector_count;
        logic [7:0] status_byte;
        logic st_nb_fail;
        logic st_nb_ok;
        logic st_rdy_fail;
        logic st_rdy_ok;
        logic st_drq_ok;
        logic [15:0] data_word;
    } cls_item_t;

endpackage
`default_nettype wire

### hw/rtl/ata_if.sv
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps
`default_nettype none
interface ata_in_if;
    import ata_pkg::*;
    logic valid;
    logic ready;
    in_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ata_out_if;
    import ata_pkg::*;
    logic valid;
    logic ready;
    out_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### hw/rtl/ata_front.sv
// Front part: accepts input items, classifies them and queues them for the back part.
`timescale 1ns / 1ps
`default_nettype none
module ata_front
    import ata_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    ata_in_if.sink in_ch,
    output cls_item_t q_item,
    output logic q_valid,
    input wire logic q_pop
);

    cls_item_t mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_AW:0] count_reg;
    cls_item_t cls;
    logic push;
    logic [7:0] s;

    assign in_ch.ready = count_reg < (QUEUE_AW+1)'(QUEUE_DEPTH);
    assign push = in_ch.valid && in_ch.ready;
    assign s = in_ch.payload.status_byte;

    always_comb
    begin
        cls.mode = in_ch.payload.mode;
        cls.op = in_ch.payload.op;
        cls.bus_index = in_ch.payload.bus_index;
        cls.drive_index = in_ch.payload.drive_index;
        cls.addr_too_big = |in_ch.payload.block_address[47:ADDRESS_BITS];
        cls.address = in_ch.payload.block_address[ADDRESS_BITS-1:0];
        cls.sector_count = in_ch.payload.sector_count;
        cls.status_byte = s;
        cls.st_nb_fail = (s == 8'h00) || (s == 8'hff);
        cls.st_nb_ok = !s[7];
        cls.st_rdy_fail = s[5] || s[0];
        cls.st_rdy_ok = s[6];
        cls.st_drq_ok = s[3];
        cls.data_word = in_ch.payload.data_word;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(q_pop);
        end
    end

    assign q_valid = count_reg != '0;
    assign q_item = mem_reg[rd_ptr_reg];

endmodule
`default_nettype wire

### hw/rtl/ata_back.sv
// Back part: runs the command sequence and emits result transfers one per cycle while out_ch is ready.
`timescale 1ns / 1ps
`default_nettype none
module ata_back
    import ata_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic cfg_we,
    input wire logic [15:0] cfg_wdata,
    input cls_item_t q_item,
    input wire logic q_valid,
    output logic q_pop,
    ata_out_if.source out_ch
);

    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_RW_NB = 4'd1;
    localparam logic [3:0] PH_RW_RDY = 4'd2;
    localparam logic [3:0] PH_SEC_NB = 4'd3;
    localparam logic [3:0] PH_SEC_DRQ = 4'd4;
    localparam logic [3:0] PH_RD_DATA = 4'd5;
    localparam logic [3:0] PH_WR_DATA = 4'd6;
    localparam logic [3:0] PH_ID_NB0 = 4'd7;
    localparam logic [3:0] PH_ID_NB1 = 4'd8;
    localparam logic [3:0] PH_ID_RDY = 4'd9;
    localparam logic [3:0] PH_ID_DATA = 4'd10;

    logic [15:0] poll_limit_reg;
    logic [3:0] phase_reg, phase_next;
    logic [1:0] op_reg, op_next;
    logic bus_reg, bus_next;
    logic [27:0] addr_reg, addr_next;
    logic [8:0] left_reg, left_next;
    logic [8:0] widx_reg, widx_next;
    logic [15:0] poll_reg, poll_next;
    logic [2:0] flags_reg, flags_next;
    logic [31:0] cap_s_reg, cap_s_next;
    logic [27:0] cap_l_reg, cap_l_next;

    // Result list of the item in hand, sent one entry per cycle while out_ch is ready.
    out_item_t res_reg [6];
    out_item_t res_next [6];
    logic [2:0] rn_reg, rn_next;
    logic [2:0] ri_reg, ri_next;
    out_item_t list [6];
    logic [2:0] n;
    logic busy;
    logic take;
    logic [15:0] plim;
    logic [15:0] poll_inc;
    logic [8:0] widx_inc;
    logic [8:0] left_dec;
    logic ok;
    logic fail;

    function automatic out_item_t mk(input logic [1:0] k, input logic b, input logic [2:0] r,
                                     input logic [15:0] v, input logic [1:0] e,
                                     input logic [27:0] c);
        out_item_t o;
        o.kind = k;
        o.bus_out = b;
        o.register_index = r;
        o.value = v;
        o.error_code = e;
        o.capacity = c;
        o.last = 1'b0;
        return o;
    endfunction

    assign busy = rn_reg != 3'd0;
    assign take = q_valid && (!busy || (out_ch.ready && ri_reg == rn_reg - 3'd1));
    assign q_pop = take;
    assign plim = (poll_limit_reg == 16'd0) ? 16'd1 : poll_limit_reg;
    assign poll_inc = poll_reg + 16'd1;
    assign widx_inc = widx_reg + 9'd1;
    assign left_dec = left_reg - 9'd1;

    always_comb
    begin
        phase_next = phase_reg;
        op_next = op_reg;
        bus_next = bus_reg;
        addr_next = addr_reg;
        left_next = left_reg;
        widx_next = widx_reg;
        poll_next = poll_reg;
        flags_next = flags_reg;
        cap_s_next = cap_s_reg;
        cap_l_next = cap_l_reg;
        n = 3'd0;
        ok = 1'b0;
        fail = 1'b0;
        for (int i = 0; i < 6; i++)
        begin
            list[i] = '0;
        end
        unique case (q_item.mode)
            MODE_CMD:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    op_next = q_item.op;
                    bus_next = q_item.bus_index;
                    if (q_item.op == OP_IDENTIFY)
                    begin
                        list[0] = mk(KIND_REG_WRITE, q_item.bus_index, REG_DRIVE,
                                     {8'd0, DRIVE_BASE | {3'd0, q_item.drive_index, 4'd0}},
                                     ERR_NONE, '0);
                        list[1] = mk(KIND_REG_READ, q_item.bus_index, REG_CMD, '0, ERR_NONE,
                                     '0);
                        n = 3'd2;
                        phase_next = PH_ID_NB0;
                        poll_next = '0;
                    end
                    else if (q_item.op == 2'd3 || q_item.addr_too_big)
                    begin
                        list[0] = mk(KIND_DONE, 1'b0, REG_DATA, '0, ERR_IO, '0);
                        n = 3'd1;
                    end
                    else
                    begin
                        addr_next = q_item.address;
                        left_next = (q_item.sector_count == 8'd0) ? 9'd256
                                    : {1'b0, q_item.sector_count};
                        list[0] = mk(KIND_REG_WRITE, q_item.bus_index, REG_DRIVE,
                                     {8'd0, DRIVE_BASE | {3'd0, q_item.drive_index,
                                                          q_item.address[27:24]}},
                                     ERR_NONE, '0);
                        list[1] = mk(KIND_REG_READ, q_item.bus_index, REG_CMD, '0, ERR_NONE,
                                     '0);
                        n = 3'd2;
                        phase_next = PH_RW_NB;
                        poll_next = '0;
                    end
                end
            end
            MODE_STATUS:
            begin
                if (phase_reg == PH_RW_NB || phase_reg == PH_SEC_NB ||
                    phase_reg == PH_ID_NB0 || phase_reg == PH_ID_NB1)
                begin
                    fail = q_item.st_nb_fail;
                    ok = q_item.st_nb_ok;
                end
                else if (phase_reg == PH_RW_RDY || phase_reg == PH_ID_RDY)
                begin
                    fail = q_item.st_rdy_fail;
                    ok = q_item.st_rdy_ok;
                end
                else if (phase_reg == PH_SEC_DRQ)
                begin
                    fail = q_item.st_rdy_fail;
                    ok = q_item.st_drq_ok;
                end
                if (phase_reg == PH_IDLE || phase_reg == PH_RD_DATA ||
                    phase_reg == PH_WR_DATA || phase_reg == PH_ID_DATA)
                begin
                    n = 3'd0;
                end
                else if (fail)
                begin
                    list[0] = mk(KIND_DONE, 1'b0, REG_DATA, '0, ERR_IO, '0);
                    n = 3'd1;
                    phase_next = PH_IDLE;
                end
                else if (!ok)
                begin
                    poll_next = poll_inc;
                    if (poll_inc >= plim)
                    begin
                        list[0] = mk(KIND_DONE, 1'b0, REG_DATA, '0, ERR_POLL_EXPIRED, '0);
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        list[0] = mk(KIND_REG_READ, bus_reg, REG_CMD, '0, ERR_NONE, '0);
                    end
                    n = 3'd1;
                end
                else
                begin
                    poll_next = '0;
                    list[0] = mk(KIND_REG_READ, bus_reg, REG_CMD, '0, ERR_NONE, '0);
                    n = 3'd1;
                    unique case (phase_reg)
                        PH_RW_NB: phase_next = PH_RW_RDY;
                        PH_RW_RDY:
                        begin
                            list[0] = mk(KIND_REG_WRITE, bus_reg, REG_COUNT,
                                         {8'd0, left_reg[7:0]}, ERR_NONE, '0);
                            list[1] = mk(KIND_REG_WRITE, bus_reg, REG_LBA0,
                                         {8'd0, addr_reg[7:0]}, ERR_NONE, '0);
                            list[2] = mk(KIND_REG_WRITE, bus_reg, REG_LBA1,
                                         {8'd0, addr_reg[15:8]}, ERR_NONE, '0);
                            list[3] = mk(KIND_REG_WRITE, bus_reg, REG_LBA2,
                                         {8'd0, addr_reg[23:16]}, ERR_NONE, '0);
                            list[4] = mk(KIND_REG_WRITE, bus_reg, REG_CMD,
                                         {8'd0, (op_reg == OP_WRITE) ? CMD_WRITE : CMD_READ},
                                         ERR_NONE, '0);
                            list[5] = mk(KIND_REG_READ, bus_reg, REG_CMD, '0, ERR_NONE, '0);
                            n = 3'd6;
                            phase_next = PH_SEC_NB;
                        end
                        PH_SEC_NB: phase_next = PH_SEC_DRQ;
                        PH_SEC_DRQ:
                        begin
                            widx_next = '0;
                            if (op_reg == OP_WRITE)
                            begin
                                phase_next = PH_WR_DATA;
                                n = 3'd0;
                            end
                            else
                            begin
                                phase_next = PH_RD_DATA;
                                list[0] = mk(KIND_REG_READ, bus_reg, REG_DATA, '0, ERR_NONE,
                                             '0);
                            end
                        end
                        PH_ID_NB0:
                        begin
                            list[0] = mk(KIND_REG_WRITE, bus_reg, REG_CMD,
                                         {8'd0, CMD_IDENTIFY}, ERR_NONE, '0);
                            list[1] = mk(KIND_REG_READ, bus_reg, REG_CMD, '0, ERR_NONE, '0);
                            n = 3'd2;
                            phase_next = PH_ID_NB1;
                        end
                        PH_ID_NB1: phase_next = PH_ID_RDY;
                        default:
                        begin
                            widx_next = '0;
                            phase_next = PH_ID_DATA;
                            list[0] = mk(KIND_REG_READ, bus_reg, REG_DATA, '0, ERR_NONE, '0);
                        end
                    endcase
                end
            end
            MODE_DEV_WORD:
            begin
                if (phase_reg == PH_RD_DATA || phase_reg == PH_ID_DATA)
                begin
                    list[0] = mk(KIND_HOST_WORD, 1'b0, REG_DATA, q_item.data_word, ERR_NONE,
                                 '0);
                    n = 3'd2;
                    widx_next = widx_inc;
                    if (phase_reg == PH_ID_DATA)
                    begin
                        case (widx_reg)
                            9'd0: flags_next[0] = q_item.data_word[15];
                            9'd49: flags_next[1] = q_item.data_word[9];
                            9'd60: cap_s_next[15:0] = q_item.data_word;
                            9'd61: cap_s_next[31:16] = q_item.data_word;
                            9'd83: flags_next[2] = q_item.data_word[10];
                            9'd100: cap_l_next[15:0] = q_item.data_word;
                            9'd101: cap_l_next[27:16] = q_item.data_word[11:0];
                            default: ;
                        endcase
                    end
                    if (widx_inc < 9'(WORDS_PER_SECTOR))
                    begin
                        list[1] = mk(KIND_REG_READ, bus_reg, REG_DATA, '0, ERR_NONE, '0);
                    end
                    else if (phase_reg == PH_RD_DATA)
                    begin
                        left_next = left_dec;
                        if (left_dec == 9'd0)
                        begin
                            list[1] = mk(KIND_DONE, 1'b0, REG_DATA, '0, ERR_NONE, '0);
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            list[1] = mk(KIND_REG_READ, bus_reg, REG_CMD, '0, ERR_NONE, '0);
                            phase_next = PH_SEC_NB;
                            poll_next = '0;
                        end
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        if (flags_next[0] || !flags_next[1])
                        begin
                            list[1] = mk(KIND_DONE, 1'b0, REG_DATA, '0, ERR_IO, '0);
                        end
                        else
                        begin
                            list[1] = mk(KIND_DONE, 1'b0, REG_DATA, '0, ERR_NONE,
                                         flags_next[2] ? cap_l_next : cap_s_next[27:0]);
                        end
                    end
                end
            end
            default:
            begin
                if (phase_reg == PH_WR_DATA)
                begin
                    list[0] = mk(KIND_REG_WRITE, bus_reg, REG_DATA, q_item.data_word,
                                 ERR_NONE, '0);
                    n = 3'd1;
                    widx_next = widx_inc;
                    if (widx_inc >= 9'(WORDS_PER_SECTOR))
                    begin
                        left_next = left_dec;
                        n = 3'd2;
                        if (left_dec == 9'd0)
                        begin
                            list[1] = mk(KIND_DONE, 1'b0, REG_DATA, '0, ERR_NONE, '0);
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            list[1] = mk(KIND_REG_READ, bus_reg, REG_CMD, '0, ERR_NONE, '0);
                            phase_next = PH_SEC_NB;
                            poll_next = '0;
                        end
                    end
                end
            end
        endcase
        for (int i = 0; i < 6; i++)
        begin
            list[i].last = (3'(i) == n - 3'd1);
        end
    end

    always_comb
    begin
        rn_next = rn_reg;
        ri_next = ri_reg;
        for (int i = 0; i < 6; i++)
        begin
            res_next[i] = res_reg[i];
        end
        if (busy && out_ch.ready)
        begin
            ri_next = ri_reg + 3'd1;
            if (ri_reg == rn_reg - 3'd1)
            begin
                rn_next = 3'd0;
            end
        end
        if (take)
        begin
            rn_next = n;
            ri_next = 3'd0;
            for (int i = 0; i < 6; i++)
            begin
                res_next[i] = list[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 6; i++)
        begin
            res_reg[i] <= res_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_limit_reg <= POLL_LIMIT_RESET;
            phase_reg <= PH_IDLE;
            op_reg <= '0;
            bus_reg <= '0;
            addr_reg <= '0;
            left_reg <= '0;
            widx_reg <= '0;
            poll_reg <= '0;
            flags_reg <= '0;
            cap_s_reg <= '0;
            cap_l_reg <= '0;
            rn_reg <= '0;
            ri_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                poll_limit_reg <= cfg_wdata;
            end
            rn_reg <= rn_next;
            ri_reg <= ri_next;
            if (take)
            begin
                phase_reg <= phase_next;
                op_reg <= op_next;
                bus_reg <= bus_next;
                addr_reg <= addr_next;
                left_reg <= left_next;
                widx_reg <= widx_next;
                poll_reg <= poll_next;
                flags_reg <= flags_next;
                cap_s_reg <= cap_s_next;
                cap_l_reg <= cap_l_next;
            end
        end
    end

    assign out_ch.valid = busy;
    assign out_ch.payload = res_reg[ri_reg];

endmodule
`default_nettype wire

### hw/rtl/ata_pio_command_sequencer.sv
// Top level of the ATA PIO command sequencer.
//
// Channel   Direction  Handshake      Payload
// in_ch     sink       valid/ready    mode, op, bus/drive, address, count, status, word
// out_ch    source     valid/ready    kind, bus, register, value, error, capacity, last
// cfg       write      cfg_we         poll_limit (16 bits)
//
// A four-entry queue takes one input transfer per cycle while it has room.
// The back part takes the next queued item once the last result of the one before is accepted,
// and sends the results of an item one per cycle while out_ch is ready.
// Reset clears the queue and sets poll_limit to 10000; out_ch stalls hold the back part.
`timescale 1ns / 1ps
`default_nettype none
module ata_pio_command_sequencer
    import ata_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    ata_in_if.sink in_ch,
    ata_out_if.source out_ch,
    input wire logic cfg_we,
    input wire logic [15:0] cfg_wdata
);

    cls_item_t q_item;
    logic q_valid;
    logic q_pop;

    ata_front u_front (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch),
        .q_item(q_item),
        .q_valid(q_valid),
        .q_pop(q_pop)
    );

    ata_back u_back (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata),
        .q_item(q_item),
        .q_valid(q_valid),
        .q_pop(q_pop),
        .out_ch(out_ch)
    );

endmodule
`default_nettype wire
